@@ hdl/tdc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared constants, register codes and direction codes of the tilt direction
// classifier.
// ----------------------------------------------------------------------------
package tdc_pkg;

    // Width of the raw sample fields on the stream port
    localparam int FIELD_BITS       = 12;
    // Default width of the internal sample datapath
    localparam int SAMPLE_BITS_DEF  = 12;
    // Width of the squared-tangent thresholds (Q16)
    localparam int TAN_BITS         = 24;
    localparam int Q16_SHIFT        = 16;

    // Configuration port
    localparam int CFG_IDX_BITS     = 2;
    localparam int CFG_DATA_BITS    = 24;

    // Reset values of the configuration registers
    localparam logic [FIELD_BITS-1:0] MIDPOINT_RST = 12'd2048;
    localparam logic [TAN_BITS-1:0]   MIN_TAN_RST  = 24'd21845;
    localparam logic [TAN_BITS-1:0]   MAX_TAN_RST  = 24'd196608;

    // Stream payload widths (packed fields, padded to whole bytes)
    localparam int S_TDATA_BITS     = 40;
    localparam int M_TDATA_BITS     = 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIDPOINT = 2'd0,
        CFG_MIN_TAN  = 2'd1,
        CFG_MAX_TAN  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_DOWN  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_LEFT  = 3'd4
    } t_dir;

    // Active-low LED pattern for each direction
    localparam logic [2:0] LED_OFF   = 3'd7;
    localparam logic [2:0] LED_DOWN  = 3'd5;
    localparam logic [2:0] LED_RIGHT = 3'd1;
    localparam logic [2:0] LED_UP    = 3'd6;
    localparam logic [2:0] LED_LEFT  = 3'd3;

    function automatic logic [2:0] led_for_dir(input t_dir dir);
        logic [2:0] led;
        case (dir)
            DIR_DOWN:  led = LED_DOWN;
            DIR_RIGHT: led = LED_RIGHT;
            DIR_UP:    led = LED_UP;
            DIR_LEFT:  led = LED_LEFT;
            default:   led = LED_OFF;
        endcase
        return led;
    endfunction

endpackage
`default_nettype wire

@@ hdl/tdc_center.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_center
// Stage 1: trim the raw samples to the datapath width and subtract the
// zero-g midpoint, giving signed axis deltas.
// ----------------------------------------------------------------------------
module tdc_center
    import tdc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [FIELD_BITS-1:0]      i_x,
    input  wire logic [FIELD_BITS-1:0]      i_y,
    input  wire logic [FIELD_BITS-1:0]      i_z,
    input  wire logic [FIELD_BITS-1:0]      i_midpoint,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [SAMPLE_BITS:0]     o_dx,
    output logic signed [SAMPLE_BITS:0]     o_dy,
    output logic signed [SAMPLE_BITS:0]     o_dz
);

    localparam int EXT_BITS = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

    logic [EXT_BITS-1:0]           w_xe, w_ye, w_ze, w_me;
    logic signed [SAMPLE_BITS:0]   n_dx, n_dy, n_dz;
    logic                          r_valid;
    logic signed [SAMPLE_BITS:0]   r_dx, r_dy, r_dz;

    // Keep only the low SAMPLE_BITS bits of each sample and of the midpoint
    assign w_xe = EXT_BITS'(i_x);
    assign w_ye = EXT_BITS'(i_y);
    assign w_ze = EXT_BITS'(i_z);
    assign w_me = EXT_BITS'(i_midpoint);

    assign n_dx = $signed({1'b0, w_xe[SAMPLE_BITS-1:0]}) - $signed({1'b0, w_me[SAMPLE_BITS-1:0]});
    assign n_dy = $signed({1'b0, w_ye[SAMPLE_BITS-1:0]}) - $signed({1'b0, w_me[SAMPLE_BITS-1:0]});
    assign n_dz = $signed({1'b0, w_ze[SAMPLE_BITS-1:0]}) - $signed({1'b0, w_me[SAMPLE_BITS-1:0]});

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_dz <= n_dz;
        end
    end

    assign o_valid = r_valid;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_dz    = r_dz;

endmodule
`default_nettype wire

@@ hdl/tdc_square.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_square
// Stage 2: square the three axis deltas, flag a positive Z and sort the
// horizontal direction into one of four sectors.
// ----------------------------------------------------------------------------
module tdc_square
    import tdc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic signed [SAMPLE_BITS:0] i_dx,
    input  wire logic signed [SAMPLE_BITS:0] i_dy,
    input  wire logic signed [SAMPLE_BITS:0] i_dz,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [2*SAMPLE_BITS-1:0]         o_dx2,
    output logic [2*SAMPLE_BITS-1:0]         o_dy2,
    output logic [2*SAMPLE_BITS-1:0]         o_dz2,
    output logic                             o_dz_pos,
    output t_dir                             o_sector
);

    logic signed [2*SAMPLE_BITS+1:0] w_px, w_py, w_pz;
    logic signed [SAMPLE_BITS:0]     w_ndx, w_ndy;
    logic                            n_dz_pos;
    t_dir                            n_sector;
    logic                            r_valid;
    logic [2*SAMPLE_BITS-1:0]        r_dx2, r_dy2, r_dz2;
    logic                            r_dz_pos;
    t_dir                            r_sector;

    // Squares are non-negative and below 2^(2*SAMPLE_BITS)
    assign w_px = i_dx * i_dx;
    assign w_py = i_dy * i_dy;
    assign w_pz = i_dz * i_dz;

    assign w_ndx = -i_dx;
    assign w_ndy = -i_dy;

    assign n_dz_pos = !i_dz[SAMPLE_BITS] && (i_dz != '0);

    // Boundaries: 45 to right, 135 to up, 225 to left, 315 to down;
    // a zero horizontal component counts as down.
    always_comb begin
        if (i_dx == '0 && i_dy == '0) begin
            n_sector = DIR_DOWN;
        end else if (i_dx > 0 && w_ndx <= i_dy && i_dy < i_dx) begin
            n_sector = DIR_DOWN;
        end else if (i_dy > 0 && w_ndy < i_dx && i_dx <= i_dy) begin
            n_sector = DIR_RIGHT;
        end else if (i_dx < 0 && i_dx < i_dy && i_dy <= w_ndx) begin
            n_sector = DIR_UP;
        end else begin
            n_sector = DIR_LEFT;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dx2    <= w_px[2*SAMPLE_BITS-1:0];
            r_dy2    <= w_py[2*SAMPLE_BITS-1:0];
            r_dz2    <= w_pz[2*SAMPLE_BITS-1:0];
            r_dz_pos <= n_dz_pos;
            r_sector <= n_sector;
        end
    end

    assign o_valid  = r_valid;
    assign o_dx2    = r_dx2;
    assign o_dy2    = r_dy2;
    assign o_dz2    = r_dz2;
    assign o_dz_pos = r_dz_pos;
    assign o_sector = r_sector;

endmodule
`default_nettype wire

@@ hdl/tdc_product.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_product
// Stage 3: scale Z squared by both thresholds and sum the horizontal squares.
// ----------------------------------------------------------------------------
module tdc_product
    import tdc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [2*SAMPLE_BITS-1:0]        i_dx2,
    input  wire logic [2*SAMPLE_BITS-1:0]        i_dy2,
    input  wire logic [2*SAMPLE_BITS-1:0]        i_dz2,
    input  wire logic                            i_dz_pos,
    input  wire t_dir                            i_sector,
    input  wire logic [TAN_BITS-1:0]             i_min_tan,
    input  wire logic [TAN_BITS-1:0]             i_max_tan,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [2*SAMPLE_BITS:0]               o_h2,
    output logic [2*SAMPLE_BITS+TAN_BITS-1:0]    o_lo,
    output logic [2*SAMPLE_BITS+TAN_BITS-1:0]    o_hi,
    output logic                                 o_dz_pos,
    output t_dir                                 o_sector
);

    localparam int PROD_BITS = 2*SAMPLE_BITS + TAN_BITS;
    localparam int H2_BITS   = 2*SAMPLE_BITS + 1;

    logic [PROD_BITS-1:0] n_lo, n_hi;
    logic [H2_BITS-1:0]   n_h2;
    logic                 r_valid;
    logic [PROD_BITS-1:0] r_lo, r_hi;
    logic [H2_BITS-1:0]   r_h2;
    logic                 r_dz_pos;
    t_dir                 r_sector;

    assign n_lo = PROD_BITS'(i_dz2) * PROD_BITS'(i_min_tan);
    assign n_hi = PROD_BITS'(i_dz2) * PROD_BITS'(i_max_tan);
    assign n_h2 = H2_BITS'(i_dx2) + H2_BITS'(i_dy2);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_h2     <= n_h2;
            r_dz_pos <= i_dz_pos;
            r_sector <= i_sector;
        end
    end

    assign o_valid  = r_valid;
    assign o_h2     = r_h2;
    assign o_lo     = r_lo;
    assign o_hi     = r_hi;
    assign o_dz_pos = r_dz_pos;
    assign o_sector = r_sector;

endmodule
`default_nettype wire

@@ hdl/tdc_decide.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_decide
// Stage 4: compare the scaled horizontal square against both bounds and
// register the direction code and LED pattern for the output stream.
// ----------------------------------------------------------------------------
module tdc_decide
    import tdc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [2*SAMPLE_BITS:0]          i_h2,
    input  wire logic [2*SAMPLE_BITS+TAN_BITS-1:0] i_lo,
    input  wire logic [2*SAMPLE_BITS+TAN_BITS-1:0] i_hi,
    input  wire logic                            i_dz_pos,
    input  wire t_dir                            i_sector,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output t_dir                                 o_dir,
    output logic [2:0]                           o_led
);

    localparam int PROD_BITS = 2*SAMPLE_BITS + TAN_BITS;

    logic [PROD_BITS-1:0] w_h2_q16;
    logic                 w_in_band;
    t_dir                 n_dir;
    logic                 r_valid;
    t_dir                 r_dir;
    logic [2:0]           r_led;

    // Horizontal square in Q16, same scale as the threshold products
    assign w_h2_q16  = PROD_BITS'(i_h2) << Q16_SHIFT;
    assign w_in_band = i_dz_pos && (i_lo <= w_h2_q16) && (w_h2_q16 <= i_hi);
    assign n_dir     = w_in_band ? i_sector : DIR_NONE;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dir <= n_dir;
            r_led <= led_for_dir(n_dir);
        end
    end

    assign o_valid = r_valid;
    assign o_dir   = r_dir;
    assign o_led   = r_led;

endmodule
`default_nettype wire

@@ hdl/tilt_direction_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_direction_classifier
// Classifies accelerometer sample triples into a tilt direction and an
// active-low LED pattern, four register stages deep.
// ----------------------------------------------------------------------------
// One transfer in gives exactly one transfer out from the last stage when the
// output side is ready. The block takes one sample triple per clock cycle;
// that rate holds as long as the output side takes a result each cycle, and
// the ready chain through the four stages lets bubbles close up while the
// output stalls. Each sample has the midpoint removed, then the tilt is in
// band when Z is positive and min_tan_sq*dz^2 <= (dx^2+dy^2)<<16 <=
// max_tan_sq*dz^2 (Q16 thresholds, both bounds inclusive). An in-band tilt is
// sorted into four 90-degree sectors centered on the axes: 45 degrees goes to
// right, 135 to up, 225 to left, 315 to down, and a zero horizontal component
// to down. Stages: center, square and sector, threshold products, compare
// and output register. Write configuration only while no transfer is in
// flight; a write to an index beyond the register list is dropped.
// ----------------------------------------------------------------------------
module tilt_direction_classifier
    import tdc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Input stream
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    // [11:0] x_sample, [23:12] y_sample, [35:24] z_sample, [39:36] zero
    input  wire logic [S_TDATA_BITS-1:0]  i_s_tdata,
    // Output stream
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    // [2:0] direction, [5:3] led_pattern, [7:6] zero
    output logic [M_TDATA_BITS-1:0]       o_m_tdata,
    // Configuration write port
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int PROD_BITS = 2*SAMPLE_BITS + TAN_BITS;

    // Configuration registers
    logic [FIELD_BITS-1:0] r_midpoint;
    logic [TAN_BITS-1:0]   r_min_tan;
    logic [TAN_BITS-1:0]   r_max_tan;

    // Stage 1 -> 2
    logic                        w_c_valid, w_c_ready;
    logic signed [SAMPLE_BITS:0] w_dx, w_dy, w_dz;
    // Stage 2 -> 3
    logic                        w_q_valid, w_q_ready;
    logic [2*SAMPLE_BITS-1:0]    w_dx2, w_dy2, w_dz2;
    logic                        w_q_dz_pos;
    t_dir                        w_q_sector;
    // Stage 3 -> 4
    logic                        w_p_valid, w_p_ready;
    logic [2*SAMPLE_BITS:0]      w_h2;
    logic [PROD_BITS-1:0]        w_lo, w_hi;
    logic                        w_p_dz_pos;
    t_dir                        w_p_sector;
    // Stage 4 outputs
    t_dir                        w_dir;
    logic [2:0]                  w_led;

    // Configuration writes: take effect at the clock edge, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_midpoint <= MIDPOINT_RST;
            r_min_tan  <= MIN_TAN_RST;
            r_max_tan  <= MAX_TAN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIDPOINT: r_midpoint <= i_cfg_data[FIELD_BITS-1:0];
                CFG_MIN_TAN:  r_min_tan  <= i_cfg_data[TAN_BITS-1:0];
                CFG_MAX_TAN:  r_max_tan  <= i_cfg_data[TAN_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Stage 1: remove the midpoint
    tdc_center #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_center (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_x        (i_s_tdata[FIELD_BITS-1:0]),
        .i_y        (i_s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
        .i_z        (i_s_tdata[3*FIELD_BITS-1:2*FIELD_BITS]),
        .i_midpoint (r_midpoint),
        .o_valid    (w_c_valid),
        .i_ready    (w_c_ready),
        .o_dx       (w_dx),
        .o_dy       (w_dy),
        .o_dz       (w_dz)
    );

    // Stage 2: squares and sector
    tdc_square #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_c_valid),
        .o_ready  (w_c_ready),
        .i_dx     (w_dx),
        .i_dy     (w_dy),
        .i_dz     (w_dz),
        .o_valid  (w_q_valid),
        .i_ready  (w_q_ready),
        .o_dx2    (w_dx2),
        .o_dy2    (w_dy2),
        .o_dz2    (w_dz2),
        .o_dz_pos (w_q_dz_pos),
        .o_sector (w_q_sector)
    );

    // Stage 3: threshold products
    tdc_product #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_product (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .o_ready   (w_q_ready),
        .i_dx2     (w_dx2),
        .i_dy2     (w_dy2),
        .i_dz2     (w_dz2),
        .i_dz_pos  (w_q_dz_pos),
        .i_sector  (w_q_sector),
        .i_min_tan (r_min_tan),
        .i_max_tan (r_max_tan),
        .o_valid   (w_p_valid),
        .i_ready   (w_p_ready),
        .o_h2      (w_h2),
        .o_lo      (w_lo),
        .o_hi      (w_hi),
        .o_dz_pos  (w_p_dz_pos),
        .o_sector  (w_p_sector)
    );

    // Stage 4: band test and output register
    tdc_decide #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_p_valid),
        .o_ready  (w_p_ready),
        .i_h2     (w_h2),
        .i_lo     (w_lo),
        .i_hi     (w_hi),
        .i_dz_pos (w_p_dz_pos),
        .i_sector (w_p_sector),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_dir    (w_dir),
        .o_led    (w_led)
    );

    // Pack the result: direction low, LED pattern above, zero fill
    assign o_m_tdata = {2'b00, w_led, w_dir};

endmodule
`default_nettype wire

@@ bench/tilt_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tilt_result_checker
// Watches the sample, result and configuration ports of the tilt direction
// classifier. It works out the direction and LED pattern of each accepted
// sample triple and compares every accepted result with the oldest one
// still awaited.
// ----------------------------------------------------------------------------
module tilt_result_checker
    import tdc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_tvalid,
    input  wire logic                     i_s_tready,
    // [11:0] x_sample, [23:12] y_sample, [35:24] z_sample, [39:36] zero
    input  wire logic [S_TDATA_BITS-1:0]  i_s_tdata,
    input  wire logic                     i_m_tvalid,
    input  wire logic                     i_m_tready,
    // [2:0] direction, [5:3] led_pattern, [7:6] zero
    input  wire logic [M_TDATA_BITS-1:0]  i_m_tdata,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_dir       dir;
        logic [2:0] led;
    } t_tilt_result;

    logic [FIELD_BITS-1:0] midpoint_q;
    logic [TAN_BITS-1:0]   min_tan_q;
    logic [TAN_BITS-1:0]   max_tan_q;
    t_tilt_result          awaited_results[$];

    // Band test on squared magnitudes, then sector by signed comparisons
    function automatic t_tilt_result predict_tilt(input logic [FIELD_BITS-1:0] x_raw,
                                                  input logic [FIELD_BITS-1:0] y_raw,
                                                  input logic [FIELD_BITS-1:0] z_raw);
        longint       dx, dy, dz, vert_sq, horiz_q16;
        t_tilt_result res;
        dx = longint'(x_raw) - longint'(midpoint_q);
        dy = longint'(y_raw) - longint'(midpoint_q);
        dz = longint'(z_raw) - longint'(midpoint_q);
        res.dir = DIR_NONE;
        if (dz > 0) begin
            vert_sq   = dz * dz;
            horiz_q16 = (dx * dx + dy * dy) << Q16_SHIFT;
            if (longint'(min_tan_q) * vert_sq <= horiz_q16 &&
                horiz_q16 <= longint'(max_tan_q) * vert_sq) begin
                if (dx == 0 && dy == 0)
                    res.dir = DIR_DOWN;
                else if (dx > 0 && -dx <= dy && dy < dx)
                    res.dir = DIR_DOWN;
                else if (dy > 0 && -dy < dx && dx <= dy)
                    res.dir = DIR_RIGHT;
                else if (dx < 0 && dx < dy && dy <= -dx)
                    res.dir = DIR_UP;
                else
                    res.dir = DIR_LEFT;
            end
        end
        case (res.dir)
            DIR_DOWN:  res.led = LED_DOWN;
            DIR_RIGHT: res.led = LED_RIGHT;
            DIR_UP:    res.led = LED_UP;
            DIR_LEFT:  res.led = LED_LEFT;
            default:   res.led = LED_OFF;
        endcase
        return res;
    endfunction

    task automatic flag_failure(input string what);
        if (o_fail_count < MAX_REPORTS)
            $display("%0t: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_tilt_result want;
        t_tilt_result got;
        if (!i_rst_n) begin
            midpoint_q = MIDPOINT_RST;
            min_tan_q  = MIN_TAN_RST;
            max_tan_q  = MAX_TAN_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIDPOINT: midpoint_q = i_cfg_data[FIELD_BITS-1:0];
                    CFG_MIN_TAN:  min_tan_q  = i_cfg_data[TAN_BITS-1:0];
                    CFG_MAX_TAN:  max_tan_q  = i_cfg_data[TAN_BITS-1:0];
                    default: ;  // drop writes past the register list
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.dir = t_dir'(i_m_tdata[2:0]);
                got.led = i_m_tdata[5:3];
                if (awaited_results.size() == 0) begin
                    flag_failure($sformatf("unexpected result: dir %0d led %0d",
                                           got.dir, got.led));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.dir != want.dir || got.led != want.led)
                        flag_failure($sformatf(
                            "result mismatch: expected dir %0d led %0d, got dir %0d led %0d",
                            want.dir, want.led, got.dir, got.led));
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(predict_tilt(i_s_tdata[11:0], i_s_tdata[23:12],
                                                       i_s_tdata[35:24]));
        end
        o_pending = awaited_results.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tilt direction classifier. A directed set of
// sample triples covers the axes, the sector borders, the band edges and the
// odd register settings; then random triples run under twelve register
// settings and three idling mixes, with a long output stall in each mix.
// ----------------------------------------------------------------------------
module tb_top
    import tdc_pkg::*;
();

    localparam int COUNT_MAX      = (1 << FIELD_BITS) - 1;
    localparam int TAN_MAX        = (1 << TAN_BITS) - 1;
    localparam int Q16_ONE        = 1 << Q16_SHIFT;
    // Index past the register list; the block must drop writes to it
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;
    // Quiet cycles after the last awaited result; all four register stages are empty
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 120;
    localparam int ITEMS_PER_SET  = 108;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       fail_count;
    int                       pending;

    // Idle odds in percent, set per phase by the stimulus process
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Long output stalls: the stimulus asks, the receiver serves
    int hold_reqs = 0;
    int hold_done = 0;
    // Midpoint last written, so offsets can be turned into raw counts
    int mid_now = int'(MIDPOINT_RST);

    tilt_direction_classifier dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tilt_result_checker u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Saturate a centered value back into the ADC count range
    function automatic logic [FIELD_BITS-1:0] fit_count(input int v);
        if (v < 0)
            return '0;
        if (v > COUNT_MAX)
            return '1;
        return v[FIELD_BITS-1:0];
    endfunction

    // Offer one sample triple and hold it until the transfer happens.
    // Enter and leave just after a falling edge.
    task automatic send_sample(input logic [FIELD_BITS-1:0] x_raw,
                               input logic [FIELD_BITS-1:0] y_raw,
                               input logic [FIELD_BITS-1:0] z_raw);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_BITS - 3 * FIELD_BITS){1'b0}}, z_raw, y_raw, x_raw};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Offer a triple given as offsets from the current midpoint
    task automatic send_offset(input int dx, input int dy, input int dz);
        send_sample(fit_count(mid_now + dx), fit_count(mid_now + dy),
                    fit_count(mid_now + dz));
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0]  idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_MIDPOINT)
            mid_now = int'(data[FIELD_BITS-1:0]);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering, wait for every awaited result, then let the pipe drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Output side: random back-pressure, plus a long stall on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_done != hold_reqs) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done++;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Abort when no transfer happens on either side for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int set_no;
        int mid_val;
        int min_val;
        int max_val;
        int mode;
        int dx;
        int dy;
        int dz;
        int reach;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 15;
        recv_idle_pct = 59;

        // Directed part under the reset register values
        send_sample('0, '0, '0);              // all-zero counts, Z negative
        send_sample('1, '1, '1);              // full-scale counts, lands on 45 degrees
        send_offset(500, 0, 0);               // Z exactly at midpoint
        send_offset(500, 0, -500);            // Z below midpoint
        send_offset(500, 0, 500);             // each axis
        send_offset(0, 500, 500);
        send_offset(-500, 0, 500);
        send_offset(0, -500, 500);
        send_offset(400, 400, 500);           // sector borders at 45, 135, 225, 315
        send_offset(-400, 400, 500);
        send_offset(-400, -400, 500);
        send_offset(400, -400, 500);
        send_offset(200, 0, 500);             // too close to vertical
        send_offset(1000, 0, 500);            // tilted past the upper bound

        // Both bounds at tan^2 = 1: probe exact equality and one count off
        settle();
        write_reg(CFG_MIN_TAN, CFG_DATA_BITS'(Q16_ONE));
        write_reg(CFG_MAX_TAN, CFG_DATA_BITS'(Q16_ONE));
        send_offset(300, 0, 300);
        send_offset(301, 0, 300);
        send_offset(0, 299, 300);
        send_offset(0, 0, 300);

        // Zero lower bound lets a level board through as down
        settle();
        write_reg(CFG_MIN_TAN, '0);
        send_offset(0, 0, 300);
        send_offset(0, 0, 0);

        // A write past the register list must leave everything as it was
        settle();
        write_reg(CFG_UNUSED_IDX, '1);
        send_offset(0, 0, 300);

        // Crossed bounds reject every tilt
        settle();
        write_reg(CFG_MIN_TAN, CFG_DATA_BITS'(2 * Q16_ONE));
        write_reg(CFG_MAX_TAN, CFG_DATA_BITS'(Q16_ONE));
        send_offset(400, 0, 300);
        send_offset(300, 0, 300);

        // Random part: three idling mixes, four register settings each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                set_no = phase * 4 + k;
                case (set_no % 4)
                    0: mid_val = int'(MIDPOINT_RST);
                    1: mid_val = 0;
                    2: mid_val = COUNT_MAX;
                    default: mid_val = $urandom_range(0, COUNT_MAX);
                endcase
                case (set_no % 3)
                    0: begin
                        min_val = $urandom_range(0, Q16_ONE);
                        max_val = min_val + $urandom_range(0, 8 * Q16_ONE);
                    end
                    1: begin
                        min_val = 0;
                        max_val = TAN_MAX;
                    end
                    default: begin
                        min_val = $urandom_range(0, TAN_MAX);
                        max_val = $urandom_range(0, TAN_MAX);
                    end
                endcase
                settle();
                write_reg(CFG_MIDPOINT, CFG_DATA_BITS'(mid_val));
                write_reg(CFG_MIN_TAN, CFG_DATA_BITS'(min_val));
                write_reg(CFG_MAX_TAN, CFG_DATA_BITS'(max_val));

                // Stall the output for a while and keep offering, so the
                // pipe fills up and the input side backs off
                if (k == 1)
                    hold_reqs++;

                repeat (ITEMS_PER_SET) begin
                    mode = $urandom_range(0, 99);
                    if (mode < 25) begin
                        // Raw noise over the whole count range
                        send_sample(FIELD_BITS'($urandom_range(0, COUNT_MAX)),
                                    FIELD_BITS'($urandom_range(0, COUNT_MAX)),
                                    FIELD_BITS'($urandom_range(0, COUNT_MAX)));
                    end else begin
                        // Z above midpoint with a horizontal part of similar size,
                        // so the band test and the sectors both get exercised
                        dz    = $urandom_range(1, $urandom_range(1, COUNT_MAX / 2));
                        reach = 2 * dz;
                        dx    = int'($urandom_range(0, 2 * reach)) - reach;
                        dy    = int'($urandom_range(0, 2 * reach)) - reach;
                        if (mode < 40) begin
                            // Pin onto a sector border or an axis
                            case ($urandom_range(0, 3))
                                0: dy = dx;
                                1: dy = -dx;
                                2: dy = 0;
                                default: dx = 0;
                            endcase
                        end
                        send_offset(dx, dy, dz);
                    end
                end
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
